>>> sv/rbf_pkg.sv
// ----------------------------------------------------------------------------
// RBF kernel evaluator package
// Shared widths, arithmetic constants, controller types and the reciprocal
// table used by the series divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned KERNEL_W = 17;
  localparam int unsigned ARG_W    = 28;  // clamped argument, unsigned Q.24
  localparam int unsigned BIG_W    = 36;  // argument in Q.32
  localparam int unsigned S_W      = 33;  // series value, up to 1.0 in Q.32
  localparam int unsigned N_W      = 5;   // whole powers of two taken out
  localparam int unsigned BIT_W    = 3;   // index into the quotient bits
  localparam int unsigned TERM_W   = 4;
  localparam int unsigned RECIP_W  = 36;

  localparam logic [SUM_W-1:0]   SUM_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd32768;
  localparam logic [ARG_W-1:0]   ARG_CLAMP   = 28'd201326592;  // 12.0 in Q.24
  localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
  localparam logic [S_W-1:0]     ONE_Q32     = 33'h1_0000_0000;
  localparam logic [TERM_W-1:0]  SERIES_TERMS = 4'd12;
  localparam logic [BIT_W-1:0]   DIV_TOP     = 3'd4;
  localparam logic [5:0]         OUT_SHIFT   = 6'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ARG,
    ST_DIV,
    ST_SER_MUL,
    ST_SER_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              accept;
    logic              mul_hi;
    logic              mul_lo;
    logic              arg;
    logic              div_step;
    logic [BIT_W-1:0]  div_bit;
    logic              ser_mul;
    logic              ser_div;
    logic [TERM_W-1:0] term;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  // ceil(2^36 / k): floor(v * m >> 36) equals floor(v / k) for any 32-bit v.
  // A divisor of one bypasses the table.
  function automatic logic [RECIP_W-1:0] recip(input logic [TERM_W-1:0] k);
    logic [RECIP_W-1:0] m;
    unique case (k)
      4'd2:    m = 36'd34359738368;
      4'd3:    m = 36'd22906492246;
      4'd4:    m = 36'd17179869184;
      4'd5:    m = 36'd13743895348;
      4'd6:    m = 36'd11453246123;
      4'd7:    m = 36'd9817068106;
      4'd8:    m = 36'd8589934592;
      4'd9:    m = 36'd7635497416;
      4'd10:   m = 36'd6871947674;
      4'd11:   m = 36'd6247225158;
      4'd12:   m = 36'd5726623062;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> sv/rbf_in_if.sv
// ----------------------------------------------------------------------------
// RBF input channel
// Valid/ready channel carrying one element pair and its last mark per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_elem;
  logic [15:0] y_elem;
  logic        last_elem;

  modport source (output valid, output x_elem, output y_elem, output last_elem,
                  input ready);
  modport sink   (input valid, input x_elem, input y_elem, input last_elem,
                  output ready);
endinterface

`default_nettype wire

>>> sv/rbf_out_if.sv
// ----------------------------------------------------------------------------
// RBF output channel
// Valid/ready channel carrying one kernel value and its saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbf_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] kernel_value;
  logic        sum_saturated;

  modport source (output valid, output kernel_value, output sum_saturated,
                  input ready);
  modport sink   (input valid, input kernel_value, input sum_saturated,
                  output ready);
endinterface

`default_nettype wire

>>> sv/rbf_ctrl.sv
// ----------------------------------------------------------------------------
// RBF controller
// Sequences accumulation, the argument product, range reduction, the Horner
// series and the output load.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  input  wire rbf_pkg::sts_t sts_i,
  output rbf_pkg::cmd_t      cmd_o
);

  rbf_pkg::state_e                  state_q, state_d;
  logic [rbf_pkg::BIT_W-1:0]        bit_q, bit_d;
  logic [rbf_pkg::TERM_W-1:0]       term_q, term_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbf_pkg::ST_IDLE;
      bit_q   <= '0;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      term_q  <= term_d;
    end
  end

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    term_d  = term_q;
    unique case (state_q)
      rbf_pkg::ST_IDLE: begin
        if (in_valid_i && in_last_i) begin
          state_d = rbf_pkg::ST_MUL_HI;
        end
      end
      rbf_pkg::ST_MUL_HI: state_d = rbf_pkg::ST_MUL_LO;
      rbf_pkg::ST_MUL_LO: state_d = rbf_pkg::ST_ARG;
      rbf_pkg::ST_ARG: begin
        bit_d   = rbf_pkg::DIV_TOP;
        state_d = rbf_pkg::ST_DIV;
      end
      rbf_pkg::ST_DIV: begin
        if (bit_q == '0) begin
          term_d  = rbf_pkg::SERIES_TERMS;
          state_d = rbf_pkg::ST_SER_MUL;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      rbf_pkg::ST_SER_MUL: state_d = rbf_pkg::ST_SER_DIV;
      rbf_pkg::ST_SER_DIV: begin
        if (term_q == 4'd1) begin
          state_d = rbf_pkg::ST_FINISH;
        end else begin
          term_d  = term_q - 1'b1;
          state_d = rbf_pkg::ST_SER_MUL;
        end
      end
      rbf_pkg::ST_FINISH: begin
        if (!sts_i.out_busy) begin
          state_d = rbf_pkg::ST_IDLE;
        end
      end
      default: state_d = rbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    cmd_o.div_bit = bit_q;
    cmd_o.term    = term_q;
    unique case (state_q)
      rbf_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      rbf_pkg::ST_MUL_HI:  cmd_o.mul_hi   = 1'b1;
      rbf_pkg::ST_MUL_LO:  cmd_o.mul_lo   = 1'b1;
      rbf_pkg::ST_ARG:     cmd_o.arg      = 1'b1;
      rbf_pkg::ST_DIV:     cmd_o.div_step = 1'b1;
      rbf_pkg::ST_SER_MUL: cmd_o.ser_mul  = 1'b1;
      rbf_pkg::ST_SER_DIV: cmd_o.ser_div  = 1'b1;
      rbf_pkg::ST_FINISH:  cmd_o.load_out = !sts_i.out_busy;
      default:             cmd_o        = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/rbf_datapath.sv
// ----------------------------------------------------------------------------
// RBF datapath
// Saturating squared-distance accumulator, gain register, argument product,
// range reduction by ln 2, shared Horner series unit and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rbf_pkg::cmd_t                 cmd_i,
  output rbf_pkg::sts_t                      sts_o,
  input  wire logic [rbf_pkg::ELEM_W-1:0]    x_elem_i,
  input  wire logic [rbf_pkg::ELEM_W-1:0]    y_elem_i,
  input  wire logic                          last_elem_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rbf_pkg::GAIN_W-1:0]    cfg_wdata_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [rbf_pkg::KERNEL_W-1:0]       kernel_value_o,
  output logic                               sum_saturated_o
);

  // Accumulation
  logic signed [16:0]              diff;
  logic [15:0]                     abs_diff;
  logic [31:0]                     sq;
  logic [rbf_pkg::SUM_W:0]         acc_sum;
  logic                            acc_sat;
  logic [rbf_pkg::SUM_W-1:0]       acc_next;
  logic [rbf_pkg::SUM_W-1:0]       acc_q;
  logic                            ovf_q;
  logic [rbf_pkg::SUM_W-1:0]       sum_q;
  logic                            sat_q;
  logic [rbf_pkg::GAIN_W-1:0]      gain_q;

  // Kernel evaluation
  logic [47:0]                     hp_d, hp_q, lp_d, lp_q;
  logic [56:0]                     p_full;
  logic [rbf_pkg::ARG_W-1:0]       p_clamped;
  logic [rbf_pkg::BIG_W-1:0]       rem_q, cand;
  logic [rbf_pkg::N_W-1:0]         n_q;
  logic [rbf_pkg::S_W-1:0]         s_q;
  logic [64:0]                     ser_prod;
  logic [31:0]                     v_q;
  logic [67:0]                     recip_prod;
  logic [31:0]                     quot;
  logic [5:0]                      out_shift;
  logic [rbf_pkg::S_W-1:0]         shifted;
  logic [rbf_pkg::KERNEL_W-1:0]    kernel_q;
  logic                            ksat_q;
  logic                            out_valid_q;

  assign diff     = $signed({x_elem_i[15], x_elem_i}) - $signed({y_elem_i[15], y_elem_i});
  assign abs_diff = diff[16] ? 16'(-diff) : diff[15:0];
  assign sq       = abs_diff * abs_diff;
  assign acc_sum  = {1'b0, acc_q} + {17'b0, sq};
  assign acc_sat  = acc_sum[rbf_pkg::SUM_W];
  assign acc_next = acc_sat ? rbf_pkg::SUM_MAX : acc_sum[rbf_pkg::SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (last_elem_i) begin
        acc_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        acc_q <= acc_next;
        ovf_q <= ovf_q | acc_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && last_elem_i) begin
      sum_q <= acc_next;
      sat_q <= ovf_q | acc_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= rbf_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // The 48 x 24 product is split into two 24 x 24 halves on separate cycles.
  assign hp_d = sum_q[47:24] * gain_q;
  assign lp_d = sum_q[23:0] * gain_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_hi) begin
      hp_q <= hp_d;
    end
    if (cmd_i.mul_lo) begin
      lp_q <= lp_d;
    end
  end

  assign p_full    = {1'b0, hp_q, 8'b0} + {25'b0, lp_q[47:16]};
  assign p_clamped = (p_full > {29'b0, rbf_pkg::ARG_CLAMP}) ? rbf_pkg::ARG_CLAMP
                                                            : p_full[rbf_pkg::ARG_W-1:0];
  assign cand      = {4'b0, rbf_pkg::LN2_Q32} << cmd_i.div_bit;

  // Series step: s = 1 - floor(floor(r * s) / k), division by reciprocal.
  assign ser_prod   = rem_q[31:0] * s_q;
  assign recip_prod = v_q * rbf_pkg::recip(cmd_i.term);
  assign quot       = (cmd_i.term == 4'd1) ? v_q : recip_prod[67:36];

  always_ff @(posedge clk_i) begin
    if (cmd_i.arg) begin
      rem_q <= {p_clamped, 8'b0};
      n_q   <= '0;
      s_q   <= rbf_pkg::ONE_Q32;
    end else if (cmd_i.div_step) begin
      if (rem_q >= cand) begin
        rem_q               <= rem_q - cand;
        n_q[cmd_i.div_bit]  <= 1'b1;
      end
    end else if (cmd_i.ser_div) begin
      s_q <= rbf_pkg::ONE_Q32 - {1'b0, quot};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ser_mul) begin
      v_q <= ser_prod[63:32];
    end
  end

  assign out_shift = rbf_pkg::OUT_SHIFT + {1'b0, n_q};
  assign shifted   = s_q >> out_shift;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      kernel_q <= shifted[rbf_pkg::KERNEL_W-1:0];
      ksat_q   <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy  = out_valid_q & ~out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign kernel_value_o  = kernel_q;
  assign sum_saturated_o = ksat_q;

`ifndef SYNTHESIS
  // Once saturated, the running sum stays pinned at full scale until cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> acc_q == rbf_pkg::SUM_MAX)
    else $error("overflow flag set while accumulator below full scale");

  // Range reduction must leave a remainder below ln 2 before the series starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ser_mul |-> rem_q < {4'b0, rbf_pkg::LN2_Q32})
    else $error("reduced argument not below ln 2");

  // The series value stays within (0, 1.0] in Q.32 throughout the iteration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ser_mul |-> (s_q <= rbf_pkg::ONE_Q32) && (s_q != '0))
    else $error("series value out of range");

  // A delivered kernel value never exceeds 1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> kernel_q <= 17'd65536)
    else $error("kernel value above 1.0");
`endif

endmodule

`default_nettype wire

>>> sv/rbf_kernel_evaluator.sv
// ----------------------------------------------------------------------------
// Gaussian RBF kernel evaluator
// Streams element pairs of two vectors and returns exp(-gain * |x - y|^2).
// ----------------------------------------------------------------------------
//
// Each input item carries one element pair (signed Q4.12) and a last mark. An
// item without the last mark is accepted in the idle state: its squared
// difference is added into a 48-bit accumulator that saturates at full scale
// and remembers that it did. The item marked last is added too, and then the
// input holds ready low while the kernel is evaluated: a high and a low step
// for the 48 x 24 gain product (one 24 x 24 half per step), one step to form
// and clamp the argument at 12.0, five steps for the restoring division by
// ln 2 that splits off the power of two, a multiply and a divide step for
// each of the twelve terms of the Horner series of exp(-r) on its shared
// multipliers, and one step to load the output register. The result waits in
// that register until it is taken, so the next vector can start accumulating
// as soon as the evaluation has ended; if an earlier result is still waiting
// when a new one is ready, the block holds until the output frees. The kernel
// value is unsigned Q1.16 with 65536 meaning 1.0, truncated, and reads 0 when
// the true value is below one LSB. The gain register (unsigned Q8.16, reset
// 0.5) is written through cfg_we_i and cfg_wdata_i and should only be changed
// while no vector is in progress.
//
`default_nettype none

module rbf_kernel_evaluator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  rbf_in_if.sink                          in_i,
  rbf_out_if.source                       out_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [rbf_pkg::GAIN_W-1:0] cfg_wdata_i
);

  rbf_pkg::cmd_t cmd;
  rbf_pkg::sts_t sts;
  logic          in_ready;

  // Controller: owns the sequence and the input handshake.
  rbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_elem),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // Datapath: accumulator, evaluation arithmetic and output register.
  rbf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .x_elem_i        (in_i.x_elem),
    .y_elem_i        (in_i.y_elem),
    .last_elem_i     (in_i.last_elem),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .kernel_value_o  (out_o.kernel_value),
    .sum_saturated_o (out_o.sum_saturated)
  );

endmodule

`default_nettype wire
